FILE: rtl/loaded_interval_set_tracker_top_defines.svh
// assertion macros used by the checker file
`ifndef LOADED_INTERVAL_SET_TRACKER_TOP_DEFINES_SVH
`define LOADED_INTERVAL_SET_TRACKER_TOP_DEFINES_SVH

// clocked assertion, silenced while reset is held
`define IST_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must hold whenever a result is offered
`define IST_ASSERT_ON_OUT(label, cond, msg) \
  `IST_ASSERT_CLK(label, out_valid |-> (cond), msg)

`endif

FILE: rtl/ist_pkg.sv
package ist_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int IDX_W         = 20;

  localparam int SLOT_W    = $clog2(MAX_INTERVALS);
  localparam int NCNT_W    = $clog2(MAX_INTERVALS + 2);
  localparam int COUNT_W   = 5;
  localparam int COV_W     = IDX_W + 1;
  localparam int ENTRY_W   = 2 * IDX_W;
  localparam int MEM_DEPTH = 2 * MAX_INTERVALS;
  localparam int MEM_AW    = SLOT_W + 1;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_QUERY  = 2'd1;
  localparam func_t FN_CLEAR  = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_REVERSED = 2'd2;

  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } req_t;

  typedef struct packed {
    logic               hit;
    status_t            status;
    logic [COUNT_W-1:0] interval_count;
    logic [COV_W-1:0]   covered_count;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [MEM_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [MEM_AW-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: rtl/ist_if.sv
interface ist_in_if;
  import ist_pkg::*;
  logic             valid;
  logic             ready;
  func_t            func;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] last_index;

  modport source (output valid, func, first_index, last_index, input ready);
  modport sink   (input valid, func, first_index, last_index, output ready);
endinterface

interface ist_out_if;
  import ist_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  status_t            status;
  logic [COUNT_W-1:0] interval_count;
  logic [COV_W-1:0]   covered_count;

  modport source (output valid, hit, status, interval_count, covered_count, input ready);
  modport sink   (input valid, hit, status, interval_count, covered_count, output ready);
endinterface

FILE: rtl/ist_ram.sv
module ist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ist_seq.sv
module ist_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  ist_pkg::req_t             req,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ist_pkg::res_t             res,
  output ist_pkg::mem_req_t         mem,
  input  logic [ist_pkg::ENTRY_W-1:0] rdata
);
  import ist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                bank_r, bank_nxt;
  logic [NCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COV_W-1:0]    cov_r, cov_nxt;
  func_t               func_r, func_nxt;
  logic [IDX_W-1:0]    f_r, f_nxt;
  logic [IDX_W-1:0]    l_r, l_nxt;
  logic [IDX_W-1:0]    ms_r, ms_nxt;
  logic [IDX_W-1:0]    me_r, me_nxt;
  logic                placed_r, placed_nxt;
  logic [NCNT_W-1:0]   n_r, n_nxt;
  logic [COV_W-1:0]    acc_r, acc_nxt;
  logic [NCNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                hit_r, hit_nxt;
  status_t             status_r, status_nxt;

  logic [IDX_W-1:0]    ent_s, ent_e;
  logic                below, above, in_span, more;
  logic                wr_req, replay;
  logic [IDX_W-1:0]    wr_s, wr_e;
  logic [COV_W-1:0]    span, acc_wr;
  logic [NCNT_W-1:0]   n_inc, n_fin;
  logic [COV_W-1:0]    acc_fin;

  assign ent_s = rdata[IDX_W-1:0];
  assign ent_e = rdata[ENTRY_W-1:IDX_W];

  // stored entry ends more than one below the new start
  assign below   = (COV_W'(ent_e) + COV_W'(1)) < COV_W'(f_r);
  // stored entry starts more than one above the new end
  assign above   = COV_W'(ent_s) > (COV_W'(l_r) + COV_W'(1));
  assign in_span = (f_r >= ent_s) && (f_r <= ent_e);
  assign more    = rd_idx_r < cnt_r;

  // write selection: a kept entry, or the merged interval
  always_comb begin
    wr_req = 1'b0;
    replay = 1'b0;
    wr_s   = ms_r;
    wr_e   = me_r;
    if (state_r == S_SCAN && pend_r && func_r == FN_INSERT) begin
      if (below) begin
        wr_req = 1'b1;
        wr_s   = ent_s;
        wr_e   = ent_e;
      end else if (above) begin
        wr_req = 1'b1;
        if (placed_r) begin
          wr_s = ent_s;
          wr_e = ent_e;
        end else begin
          replay = 1'b1;
        end
      end
    end else if (state_r == S_FIN && !placed_r) begin
      wr_req = 1'b1;
    end
  end

  assign span    = COV_W'(wr_e) - COV_W'(wr_s) + COV_W'(1);
  assign acc_wr  = acc_r + span;
  assign n_inc   = n_r + NCNT_W'(1);
  assign n_fin   = placed_r ? n_r : n_inc;
  assign acc_fin = placed_r ? acc_r : acc_wr;

  // reads come from the live bank, writes go to the other one
  assign mem.we    = wr_req && (n_r < NCNT_W'(MAX_INTERVALS));
  assign mem.waddr = {~bank_r, n_r[SLOT_W-1:0]};
  assign mem.wdata = {wr_e, wr_s};
  assign mem.raddr = replay ? {bank_r, ev_idx_r} : {bank_r, rd_idx_r[SLOT_W-1:0]};

  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    cnt_nxt    = cnt_r;
    cov_nxt    = cov_r;
    func_nxt   = func_r;
    f_nxt      = f_r;
    l_nxt      = l_r;
    ms_nxt     = ms_r;
    me_nxt     = me_r;
    placed_nxt = placed_r;
    n_nxt      = n_r;
    acc_nxt    = acc_r;
    rd_idx_nxt = rd_idx_r;
    ev_idx_nxt = ev_idx_r;
    pend_nxt   = pend_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt   = req.func;
          f_nxt      = req.first_index;
          l_nxt      = req.last_index;
          ms_nxt     = req.first_index;
          me_nxt     = req.last_index;
          placed_nxt = 1'b0;
          n_nxt      = '0;
          acc_nxt    = '0;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          if (req.func == FN_INSERT && req.last_index < req.first_index) begin
            status_nxt = ST_REVERSED;
            state_nxt  = S_DONE;
          end else if (req.func inside {FN_INSERT, FN_QUERY}) begin
            state_nxt = S_SCAN;
          end else if (req.func == FN_CLEAR) begin
            cnt_nxt   = '0;
            cov_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && func_r == FN_QUERY && in_span) begin
          hit_nxt = 1'b1;
        end
        if (pend_r && func_r == FN_INSERT && !below && !above) begin
          ms_nxt = (ent_s < ms_r) ? ent_s : ms_r;
          me_nxt = (ent_e > me_r) ? ent_e : me_r;
        end
        if (wr_req) begin
          n_nxt   = n_inc;
          acc_nxt = acc_wr;
        end
        if (replay) begin
          placed_nxt = 1'b1;
          pend_nxt   = 1'b1;
        end else if (more) begin
          pend_nxt   = 1'b1;
          ev_idx_nxt = rd_idx_r[SLOT_W-1:0];
          rd_idx_nxt = rd_idx_r + NCNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (!pend_r && !more) begin
          state_nxt = (func_r == FN_INSERT) ? S_FIN : S_DONE;
        end
      end
      S_FIN: begin
        if (n_fin > NCNT_W'(MAX_INTERVALS)) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          bank_nxt = ~bank_r;
          cnt_nxt  = n_fin;
          cov_nxt  = acc_fin;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      cnt_r   <= '0;
      cov_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      cnt_r   <= cnt_nxt;
      cov_r   <= cov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    f_r      <= f_nxt;
    l_r      <= l_nxt;
    ms_r     <= ms_nxt;
    me_r     <= me_nxt;
    placed_r <= placed_nxt;
    n_r      <= n_nxt;
    acc_r    <= acc_nxt;
    rd_idx_r <= rd_idx_nxt;
    ev_idx_r <= ev_idx_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
  end

  assign idle                 = (state_r == S_IDLE);
  assign res_valid            = (state_r == S_DONE);
  assign res.hit              = hit_r;
  assign res.status           = status_r;
  assign res.interval_count   = COUNT_W'(cnt_r);
  assign res.covered_count    = cov_r;

endmodule

FILE: rtl/loaded_interval_set_tracker_top.sv
// flow: clear, reversed insert and unused op go straight from accept to the result
// flow: query scans every stored interval, insert scans them, then commits in a finish
//   step, and rereads an entry when an insert lands between stored intervals
// throughput: one transaction at a time, paced by the scan through the interval ram
// reset: synchronous active-low rst_n empties the set and drops any pending result
module loaded_interval_set_tracker_top (
  input  logic             clk,
  input  logic             rst_n,
  ist_in_if.sink           in_ch,
  ist_out_if.source        out_ch
);
  import ist_pkg::*;

  // sequencer <-> ram
  mem_req_t            mem;
  logic [ENTRY_W-1:0]  rdata;

  // sequencer <-> result register
  req_t                req;
  res_t                res;
  logic                seq_idle;
  logic                res_valid;
  logic                res_ready;

  // output register, so a finished result can wait while the next op starts
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;

  assign req.func        = in_ch.func;
  assign req.first_index = in_ch.first_index;
  assign req.last_index  = in_ch.last_index;

  // new op taken whenever the sequencer is free
  assign in_ch.ready = seq_idle;

  // two banks of MAX_INTERVALS entries: the live list and the one being rebuilt
  // by an insert; an insert commits by flipping the bank, so read and write
  // never touch the same entry and no forwarding is needed
  ist_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  ist_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_ch.valid && seq_idle),
    .req       (req),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rdata     (rdata)
  );

  // result slot frees up when empty or drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = out_res_r.hit;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.interval_count = out_res_r.interval_count;
  assign out_ch.covered_count  = out_res_r.covered_count;

endmodule

FILE: rtl/ist_checker.sv
`include "loaded_interval_set_tracker_top_defines.svh"

module ist_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           hit,
  input ist_pkg::status_t               status,
  input logic [ist_pkg::COUNT_W-1:0]    interval_count,
  input logic [ist_pkg::COV_W-1:0]      covered_count
);
  import ist_pkg::*;

  // a stalled result stays offered and unchanged
  `IST_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(status) && $stable(interval_count) && $stable(covered_count), "result changed while stalled")

  `IST_ASSERT_ON_OUT(a_count_max, interval_count <= COUNT_W'(MAX_INTERVALS), "interval count above table size")

  // a hit needs an ok status and a nonempty set
  `IST_ASSERT_ON_OUT(a_hit_ok, !hit || (status == ST_OK && interval_count != '0), "hit without stored interval")

  // empty set iff nothing covered
  `IST_ASSERT_ON_OUT(a_empty_cov, (interval_count == '0) == (covered_count == '0), "count and coverage disagree")

endmodule

bind loaded_interval_set_tracker_top ist_checker u_ist_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .hit            (out_ch.hit),
  .status         (out_ch.status),
  .interval_count (out_ch.interval_count),
  .covered_count  (out_ch.covered_count)
);
